FILE: src/rrps_pkg.sv
// ---------------------------------------------------------------------------
// rrps_pkg: shared types and constants of the round-robin pending selector
// Command and result payloads, status and mode codes, sizing constants.
// ---------------------------------------------------------------------------
package rrps_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int COUNT_BITS   = 16;
	localparam int TOTAL_BITS   = 20;
	localparam int LAST_BITS    = 5;
	localparam int CH_BITS      = $clog2(MAX_CHANNELS);
	localparam int CFG_IDX_BITS = 4;
	localparam int CFG_DAT_BITS = 5;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	localparam logic [1:0] MODE_WRITE_DONE = 2'd0;
	localparam logic [1:0] MODE_READ_REQ   = 2'd1;
	localparam logic [1:0] MODE_READ_DONE  = 2'd2;

	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_NONE  = 3'd1;
	localparam logic [2:0] STAT_BADIX = 3'd2;
	localparam logic [2:0] STAT_UNDER = 3'd3;
	localparam logic [2:0] STAT_SAT   = 3'd4;

	localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLED       = 4'd1;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] channel;
	} cmd_t;

	typedef struct packed {
		logic       granted;
		logic [3:0] granted_channel;
		logic [2:0] status;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

FILE: src/round_robin_pending_selector.sv
// ---------------------------------------------------------------------------
// round_robin_pending_selector: per-channel pending counters with a
// round-robin grant over the channels whose count is nonzero.
// ---------------------------------------------------------------------------
// An accepted command is registered with the read of its count entry; the
// execute state writes the entry back and registers the result. Busy holds
// off a new command meanwhile, as the count memory is read and written back.
// The receiver cannot stall; each done strobe is high for one cycle only.
// Reset clears all counts at once through the nonzero flags; there is no
// clearing pass, and configuration returns to 16 channels, enabled.
module round_robin_pending_selector (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  rrps_pkg::cmd_t                        cmd,
	output logic                                  done,
	output rrps_pkg::result_t                     result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rrps_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [rrps_pkg::CFG_DAT_BITS-1:0]     cfg_data
);

	localparam int NC = rrps_pkg::MAX_CHANNELS;

	rrps_pkg::state_t state_q, state_d;

	logic [4:0]                        chan_cnt_q;
	logic                              enabled_q;
	logic [rrps_pkg::COUNT_BITS-1:0]   count_mem [NC];
	logic [rrps_pkg::COUNT_BITS-1:0]   rdata_s1;
	rrps_pkg::cmd_t                    cmd_s1;
	logic [NC-1:0]                     nz_q;
	logic [rrps_pkg::TOTAL_BITS-1:0]   total_q;
	logic [rrps_pkg::LAST_BITS-1:0]    last_q;
	rrps_pkg::result_t                 result_q;
	logic                              done_q;

	logic                              accept;
	logic                              exec;
	logic [4:0]                        n_use;
	logic [rrps_pkg::COUNT_BITS-1:0]   cur_count;
	logic                              ch_bad;
	logic [NC-1:0]                     masked;
	logic [rrps_pkg::LAST_BITS-1:0]    start_pos;
	logic [rrps_pkg::LAST_BITS-1:0]    pos_inc;
	logic                              hi_found;
	logic                              lo_found;
	logic [rrps_pkg::CH_BITS-1:0]      hi_idx;
	logic [rrps_pkg::CH_BITS-1:0]      lo_idx;
	logic [rrps_pkg::CH_BITS-1:0]      sel_idx;

	logic                              mem_we;
	logic [rrps_pkg::COUNT_BITS-1:0]   mem_wd;
	logic                              cnt_inc;
	logic                              cnt_dec;
	logic                              grant_upd;
	rrps_pkg::result_t                 res_d;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != rrps_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign exec      = (state_q == rrps_pkg::ST_EXEC);
	assign done      = done_q;
	assign result    = result_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= 5'd16;
			enabled_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == rrps_pkg::REG_CHANNEL_COUNT) begin
				chan_cnt_q <= cfg_data;
			end else if (cfg_index == rrps_pkg::REG_ENABLED) begin
				enabled_q <= cfg_data[0];
			end
		end
	end

	// Count memory: read at command acceptance, written back in the execute cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			count_mem[cmd_s1.channel] <= mem_wd;
		end
		if (accept) begin
			rdata_s1 <= count_mem[cmd.channel];
			cmd_s1   <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrps_pkg::ST_IDLE: begin
				if (accept) state_d = rrps_pkg::ST_EXEC;
			end
			rrps_pkg::ST_EXEC: begin
				state_d = rrps_pkg::ST_IDLE;
			end
			default: state_d = rrps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		if (chan_cnt_q == 5'd0) begin
			n_use = 5'd1;
		end else if (chan_cnt_q > 5'(NC)) begin
			n_use = 5'(NC);
		end else begin
			n_use = chan_cnt_q;
		end
	end

	// A memory entry whose nonzero flag is clear reads as zero.
	assign cur_count = nz_q[cmd_s1.channel] ? rdata_s1 : '0;
	assign ch_bad    = ({1'b0, cmd_s1.channel} >= n_use);

	// Rotating priority encoder over the nonzero flags of the channels in use.
	assign pos_inc   = last_q + 1'b1;
	assign start_pos = (pos_inc >= n_use) ? '0 : pos_inc;

	always_comb begin
		masked   = '0;
		hi_found = 1'b0;
		lo_found = 1'b0;
		hi_idx   = '0;
		lo_idx   = '0;
		for (int i = 0; i < NC; i++) begin
			masked[i] = nz_q[i] && (5'(i) < n_use);
		end
		for (int i = NC - 1; i >= 0; i--) begin
			if (masked[i]) begin
				lo_found = 1'b1;
				lo_idx   = rrps_pkg::CH_BITS'(i);
				if (5'(i) >= start_pos) begin
					hi_found = 1'b1;
					hi_idx   = rrps_pkg::CH_BITS'(i);
				end
			end
		end
		sel_idx = hi_found ? hi_idx : lo_idx;
	end

	always_comb begin
		res_d     = '0;
		res_d.status = rrps_pkg::STAT_OK;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		grant_upd = 1'b0;
		unique case (cmd_s1.mode)
			rrps_pkg::MODE_WRITE_DONE: begin
				priority if (!enabled_q) begin
					res_d.status = rrps_pkg::STAT_OK;
				end else if (ch_bad) begin
					res_d.status = rrps_pkg::STAT_BADIX;
				end else if (cur_count >= rrps_pkg::COUNT_MAX ||
				             total_q >= rrps_pkg::TOTAL_MAX) begin
					res_d.status = rrps_pkg::STAT_SAT;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			rrps_pkg::MODE_READ_REQ: begin
				if (total_q == '0 || !lo_found) begin
					res_d.status = rrps_pkg::STAT_NONE;
				end else begin
					res_d.granted         = 1'b1;
					res_d.granted_channel = 4'(sel_idx);
					grant_upd             = 1'b1;
				end
			end
			rrps_pkg::MODE_READ_DONE: begin
				priority if (ch_bad) begin
					res_d.status = rrps_pkg::STAT_BADIX;
				end else if (cur_count == '0 || total_q == '0) begin
					res_d.status = rrps_pkg::STAT_UNDER;
				end else begin
					cnt_dec = 1'b1;
				end
			end
			default: begin
				res_d.status = rrps_pkg::STAT_OK;
			end
		endcase
	end

	assign mem_we = exec && (cnt_inc || cnt_dec);
	assign mem_wd = cnt_inc ? (cur_count + 1'b1) : (cur_count - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q    <= '0;
			total_q <= '0;
			last_q  <= '1;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			if (exec) begin
				if (cnt_inc) begin
					nz_q[cmd_s1.channel] <= 1'b1;
					total_q <= total_q + 1'b1;
				end else if (cnt_dec) begin
					nz_q[cmd_s1.channel] <= (cur_count != rrps_pkg::COUNT_BITS'(1));
					total_q <= total_q - 1'b1;
				end
				if (grant_upd) begin
					last_q <= rrps_pkg::LAST_BITS'(sel_idx);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			result_q <= res_d;
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: round-robin pending selector
// Drives write-done, read-request and read-done commands through the start
// and busy handshake, tracks the per-channel counts and the last grant in a
// local copy, and checks every result strobe against it in order. A short
// table of directed commands and register settings comes first, then random
// phases.
// ---------------------------------------------------------------------------
module testbench;
	import rrps_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		bit         is_cfg;
		logic [4:0] chans;
		bit         en;
		cmd_t       c;
		bit         typed;
		result_t    want;
	} plan_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	cmd_t                    cmd = '0;
	logic                    done;
	result_t                 result;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DAT_BITS-1:0] cfg_data = '0;

	// Local copy of the block's state and registers.
	logic [COUNT_BITS-1:0] cnt_track [MAX_CHANNELS];
	logic [TOTAL_BITS-1:0] total_track;
	logic [LAST_BITS-1:0]  last_track;
	logic [4:0]            chans_reg;
	bit                    en_reg;

	result_t   pending_results [$];
	plan_row_t plan [$];
	result_t   want_r;
	int        n_bad = 0;

	round_robin_pending_selector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [4:0] in_use();
		if (chans_reg == 5'd0)
			return 5'd1;
		if (chans_reg > MAX_CHANNELS)
			return 5'(MAX_CHANNELS);
		return chans_reg;
	endfunction

	function automatic result_t select_and_count(input cmd_t c);
		result_t    r;
		logic [4:0] n;
		logic [4:0] pos;
		bit         hit;
		int         k;
		r = '0;
		r.status = STAT_OK;
		n = in_use();
		case (c.mode)
			MODE_WRITE_DONE: begin
				if (!en_reg)
					r.status = STAT_OK;
				else if ({1'b0, c.channel} >= n)
					r.status = STAT_BADIX;
				else if (cnt_track[c.channel] == COUNT_MAX || total_track == TOTAL_MAX)
					r.status = STAT_SAT;
				else begin
					cnt_track[c.channel] = cnt_track[c.channel] + 1'b1;
					total_track = total_track + 1'b1;
				end
			end
			MODE_READ_REQ: begin
				if (total_track == '0)
					r.status = STAT_NONE;
				else begin
					pos = last_track + 1'b1;
					if (pos >= n)
						pos = '0;
					hit = 1'b0;
					for (k = 0; k < MAX_CHANNELS; k++) begin
						if (!hit && k < n) begin
							if (cnt_track[pos[3:0]] != '0)
								hit = 1'b1;
							else begin
								pos = pos + 1'b1;
								if (pos >= n)
									pos = '0;
							end
						end
					end
					if (hit) begin
						r.granted = 1'b1;
						r.granted_channel = pos[3:0];
						last_track = pos;
					end else
						r.status = STAT_NONE;
				end
			end
			MODE_READ_DONE: begin
				if ({1'b0, c.channel} >= n)
					r.status = STAT_BADIX;
				else if (cnt_track[c.channel] == '0 || total_track == '0)
					r.status = STAT_UNDER;
				else begin
					cnt_track[c.channel] = cnt_track[c.channel] - 1'b1;
					total_track = total_track - 1'b1;
				end
			end
			default: r.status = STAT_OK;
		endcase
		return r;
	endfunction

	function automatic cmd_t random_command();
		cmd_t       c;
		int         pick;
		logic [4:0] n;
		n = in_use();
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 6) == 0)
			c.channel = 4'($urandom_range(0, 15));
		else
			c.channel = 4'($urandom_range(0, n - 1));
		if (pick < 42)
			c.mode = MODE_WRITE_DONE;
		else if (pick < 72)
			c.mode = MODE_READ_REQ;
		else if (pick < 95) begin
			c.mode = MODE_READ_DONE;
			// Half the time a read done finishes the channel last granted, if still in use.
			if ($urandom_range(0, 1) == 1 && last_track < n)
				c.channel = last_track[3:0];
		end else
			c.mode = MODE_UNUSED;
		return c;
	endfunction

	function automatic void row_cmd(input logic [1:0] m, input logic [3:0] ch);
		plan_row_t row;
		row = '{default: '0};
		row.c.mode = m;
		row.c.channel = ch;
		plan.push_back(row);
	endfunction

	function automatic void row_chk(input logic [1:0] m, input logic [3:0] ch,
			input logic g, input logic [3:0] gch, input logic [2:0] st);
		plan_row_t row;
		row = '{default: '0};
		row.c.mode = m;
		row.c.channel = ch;
		row.typed = 1'b1;
		row.want.granted = g;
		row.want.granted_channel = gch;
		row.want.status = st;
		plan.push_back(row);
	endfunction

	function automatic void row_cfg(input logic [4:0] chans, input bit en);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.chans = chans;
		row.en = en;
		plan.push_back(row);
	endfunction

	task automatic issue(input cmd_t c, input bit typed, input result_t want, input int gap);
		result_t calc;
		cmd <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		calc = select_and_count(c);
		pending_results.push_back(typed ? want : calc);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Both registers are written back to back once the block has drained.
	task automatic set_config(input logic [4:0] chans, input bit en);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_data <= chans;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		chans_reg = chans;
		cfg_index <= REG_ENABLED;
		cfg_data <= {4'b0, en};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		en_reg = en;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				if (n_bad < 10)
					$display("unexpected result: granted %0d channel %0d status %0d",
						result.granted, result.granted_channel, result.status);
				n_bad++;
			end else begin
				want_r = pending_results.pop_front();
				if (result.granted !== want_r.granted ||
						result.granted_channel !== want_r.granted_channel ||
						result.status !== want_r.status) begin
					if (n_bad < 10)
						$display("result differs: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							want_r.granted, want_r.granted_channel, want_r.status,
							result.granted, result.granted_channel, result.status);
					n_bad++;
				end
			end
		end
	end

	initial begin
		#(20_000_000);
		$display("round_robin_pending_selector: mismatch");
		$finish;
	end

	initial begin
		cmd_t       c;
		logic [4:0] chans;
		bit         en;
		bit         burst;
		int         i;
		int         ph;

		for (i = 0; i < MAX_CHANNELS; i++)
			cnt_track[i] = '0;
		total_track = '0;
		last_track = '1;
		chans_reg = 5'd16;
		en_reg = 1'b1;

		row_chk(MODE_READ_REQ, 4'd0, 1'b0, 4'd0, STAT_NONE);
		row_chk(MODE_READ_DONE, 4'd0, 1'b0, 4'd0, STAT_UNDER);
		row_cmd(MODE_WRITE_DONE, 4'd15);
		row_cmd(MODE_WRITE_DONE, 4'd0);
		row_cmd(MODE_WRITE_DONE, 4'd0);
		row_cmd(MODE_READ_REQ, 4'd15);
		row_cmd(MODE_READ_REQ, 4'd10);
		row_cmd(MODE_READ_REQ, 4'd5);
		row_cmd(MODE_READ_DONE, 4'd15);
		row_cmd(MODE_READ_DONE, 4'd0);
		row_cmd(MODE_READ_DONE, 4'd0);
		row_chk(MODE_READ_DONE, 4'd0, 1'b0, 4'd0, STAT_UNDER);
		row_chk(MODE_UNUSED, 4'd10, 1'b0, 4'd0, STAT_OK);
		row_cmd(MODE_WRITE_DONE, 4'd9);
		row_cmd(MODE_READ_REQ, 4'd0);
		// The last grant now lies beyond the four channels left in use.
		row_cfg(5'd4, 1'b1);
		row_chk(MODE_WRITE_DONE, 4'd4, 1'b0, 4'd0, STAT_BADIX);
		row_chk(MODE_READ_DONE, 4'd15, 1'b0, 4'd0, STAT_BADIX);
		row_cmd(MODE_WRITE_DONE, 4'd1);
		row_cmd(MODE_READ_REQ, 4'd3);
		row_cmd(MODE_READ_DONE, 4'd1);
		row_cmd(MODE_READ_REQ, 4'd6);
		// Disabled: write done is dropped before the index is looked at.
		row_cfg(5'd4, 1'b0);
		row_chk(MODE_WRITE_DONE, 4'd2, 1'b0, 4'd0, STAT_OK);
		row_chk(MODE_WRITE_DONE, 4'd12, 1'b0, 4'd0, STAT_OK);
		row_cfg(5'd0, 1'b1);
		row_chk(MODE_WRITE_DONE, 4'd1, 1'b0, 4'd0, STAT_BADIX);
		row_cmd(MODE_WRITE_DONE, 4'd0);
		row_cfg(5'd31, 1'b1);
		row_cmd(MODE_READ_REQ, 4'd0);
		row_cmd(MODE_READ_DONE, 4'd9);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_config(plan[i].chans, plan[i].en);
			else
				issue(plan[i].c, plan[i].typed, plan[i].want, $urandom_range(0, 18));
		end

		for (ph = 0; ph < 10; ph++) begin
			case (ph)
				0: chans = 5'd16;
				1: chans = 5'd1;
				2: chans = 5'd0;
				3: chans = 5'd31;
				default: chans = 5'($urandom_range(2, 16));
			endcase
			en = (ph == 3) ? 1'b0 : ($urandom_range(0, 5) != 0);
			set_config(chans, en);
			burst = ($urandom_range(0, 3) == 0);
			for (i = 0; i < 110; i++) begin
				c = random_command();
				issue(c, 1'b0, '0, burst ? 0 : $urandom_range(0, 18));
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (n_bad == 0 && pending_results.size() == 0)
			$display("round_robin_pending_selector: match");
		else
			$display("round_robin_pending_selector: mismatch");
		$finish;
	end

endmodule
